// File: sv/multi_trit_weighted_dot_product_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the balanced ternary dot product core
// Shared macros that the checker uses to write its concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef MULTI_TRIT_WEIGHTED_DOT_PRODUCT_CORE_MACROS_SVH
`define MULTI_TRIT_WEIGHTED_DOT_PRODUCT_CORE_MACROS_SVH

// Assertion that is checked only outside of reset.
`define MTWDP_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("mtwdp assertion failed");

// Assertion that is checked during reset as well.
`define MTWDP_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("mtwdp assertion failed");

`endif

// File: sv/mtwdp_pkg.sv
// ----------------------------------------------------------------------------
// Balanced ternary dot product package
// Beat types, saturation constants and trit helper functions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mtwdp_pkg;

  localparam int MAX_LEN      = 4096;
  localparam int PER_ELEM_MAX = 40;
  localparam int RANGE_MAX    = 163840;
  localparam int SAT_LIMIT    =
    (PER_ELEM_MAX * MAX_LEN > RANGE_MAX) ? RANGE_MAX : PER_ELEM_MAX * MAX_LEN;

  localparam int SUM_W = 20;
  localparam int DOT_W = 19;

  localparam logic signed [SUM_W-1:0] SUM_HI = SUM_W'(SAT_LIMIT);
  localparam logic signed [SUM_W-1:0] SUM_LO = -SUM_HI;
  localparam logic signed [DOT_W-1:0] DOT_HI = DOT_W'(RANGE_MAX);
  localparam logic signed [DOT_W-1:0] DOT_LO = -DOT_HI;

  typedef struct packed {
    logic [7:0] query_pixel;
    logic [7:0] ref_pixel;
    logic       last_element;
  } pix_t;

  typedef struct packed {
    logic signed [DOT_W-1:0] dot_value;
    logic                    overflow;
  } dot_t;

  // Each digit holds the trit plus one, so 0..2.
  typedef logic [3:0][1:0] trits_t;

  function automatic logic [6:0] bin_of(input logic [7:0] b);
    logic [14:0] p;
    p = 15'(b) * 15'd81;
    return p[14:8];
  endfunction

  function automatic trits_t bin_to_trits(input logic [6:0] b);
    trits_t     t;
    logic [6:0] r;
    if (b >= 7'd54) begin
      t[3] = 2'd2;
      r = b - 7'd54;
    end else if (b >= 7'd27) begin
      t[3] = 2'd1;
      r = b - 7'd27;
    end else begin
      t[3] = 2'd0;
      r = b;
    end
    if (r >= 7'd18) begin
      t[2] = 2'd2;
      r = r - 7'd18;
    end else if (r >= 7'd9) begin
      t[2] = 2'd1;
      r = r - 7'd9;
    end else begin
      t[2] = 2'd0;
    end
    if (r >= 7'd6) begin
      t[1] = 2'd2;
      r = r - 7'd6;
    end else if (r >= 7'd3) begin
      t[1] = 2'd1;
      r = r - 7'd3;
    end else begin
      t[1] = 2'd0;
    end
    t[0] = r[1:0];
    return t;
  endfunction

  // Product of two balanced trits given as digits 0..2.
  function automatic logic signed [1:0] trit_mul(input logic [1:0] a, input logic [1:0] b);
    logic signed [1:0] p;
    if (a == 2'd1 || b == 2'd1) begin
      p = 2'sd0;
    end else if (a == b) begin
      p = 2'sd1;
    end else begin
      p = -2'sd1;
    end
    return p;
  endfunction

endpackage

`default_nettype wire

// File: sv/multi_trit_weighted_dot_product_core.sv
// ----------------------------------------------------------------------------
// Balanced ternary four-plane weighted dot product core
// A result beat is registered from the last element in the element register.
// Throughput: one pair per cycle unless stalled, set by the single adder.
// The element register and the result register decouple the two channels.
// Reset clears the accumulator, the overflow flag and both valid bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module multi_trit_weighted_dot_product_core
  import mtwdp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic pix_valid,
  output logic      pix_stall,
  input  wire pix_t pix,
  output logic      dot_valid,
  input  wire logic dot_stall,
  output dot_t      dot
);

  logic s1_valid;
  pix_t s1;

  logic signed [DOT_W-1:0] acc;
  logic                    sat;

  logic                    advance;
  trits_t                  qt;
  trits_t                  rt;
  logic signed [1:0]       p3, p2, p1, p0;
  logic signed [6:0]       contrib;
  logic signed [SUM_W-1:0] sum;
  logic signed [DOT_W-1:0] acc_next;
  logic                    clamp;

  assign advance   = s1_valid && (!s1.last_element || !dot_valid || !dot_stall);
  assign pix_stall = s1_valid && !advance;

  always_comb begin
    qt = bin_to_trits(bin_of(s1.query_pixel));
    rt = bin_to_trits(bin_of(s1.ref_pixel));
    p3 = trit_mul(qt[3], rt[3]);
    p2 = trit_mul(qt[2], rt[2]);
    p1 = trit_mul(qt[1], rt[1]);
    p0 = trit_mul(qt[0], rt[0]);
    contrib = 7'(p3) * 7'sd27 + 7'(p2) * 7'sd9 + 7'(p1) * 7'sd3 + 7'(p0);
    sum = SUM_W'(acc) + SUM_W'(contrib);
    if (sum > SUM_HI) begin
      acc_next = DOT_W'(SUM_HI);
      clamp = 1'b1;
    end else if (sum < SUM_LO) begin
      acc_next = DOT_W'(SUM_LO);
      clamp = 1'b1;
    end else begin
      acc_next = sum[DOT_W-1:0];
      clamp = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      dot_valid <= 1'b0;
      acc       <= '0;
      sat       <= 1'b0;
    end else begin
      if (!pix_stall) begin
        s1_valid <= pix_valid;
      end
      if (advance) begin
        if (s1.last_element) begin
          acc       <= '0;
          sat       <= 1'b0;
          dot_valid <= 1'b1;
        end else begin
          acc <= acc_next;
          sat <= sat | clamp;
          if (!dot_stall) begin
            dot_valid <= 1'b0;
          end
        end
      end else if (!dot_stall) begin
        dot_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pix_valid && !pix_stall) begin
      s1 <= pix;
    end
    if (advance && s1.last_element) begin
      dot.dot_value <= acc_next;
      dot.overflow  <= sat | clamp;
    end
  end

endmodule

`default_nettype wire

// File: sv/mtwdp_checker.sv
// ----------------------------------------------------------------------------
// Balanced ternary dot product port checker
// Watches the core's ports and is bound to every instance of the core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "multi_trit_weighted_dot_product_core_macros.svh"

module mtwdp_checker
  import mtwdp_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic pix_valid,
  input wire logic pix_stall,
  input wire pix_t pix,
  input wire logic dot_valid,
  input wire logic dot_stall,
  input wire dot_t dot
);

  logic dot_in_range;

  assign dot_in_range = dot.dot_value <= DOT_HI && dot.dot_value >= DOT_LO;

  `MTWDP_ASSERT(a_dot_hold, clk, rst, dot_valid && dot_stall |=> dot_valid && $stable(dot))
  `MTWDP_ASSERT(a_dot_range, clk, rst, dot_valid |-> dot_in_range)
  `MTWDP_ASSERT(a_no_stall_when_empty, clk, rst, !dot_valid |-> !pix_stall)
  `MTWDP_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !dot_valid)

endmodule

bind multi_trit_weighted_dot_product_core mtwdp_checker u_mtwdp_checker (.*);

`default_nettype wire
